// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define LSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define LSC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Load switch channel controller package
// Types, codes and constant tables shared by the channel controller files.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

   localparam int DUTY_FULL  = 1000;
   localparam int DUTY_W     = 10;
   localparam int PCT_MAX    = 100;
   localparam int PCT_W      = 7;
   localparam int SEC_TO_MS  = 1000;
   localparam int MS_LIMIT_W = 26;
   localparam int CLOCK_W    = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SOURCE_SELECT = 3'd0,
      CSR_OPTION_FLAGS  = 3'd1,
      CSR_PWM_PERCENT   = 3'd2,
      CSR_HEATER_PCT    = 3'd3,
      CSR_CUTOFF_VOLT   = 3'd4,
      CSR_MAX_ON_SEC    = 3'd5,
      CSR_OFF_DELAY_SEC = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      SRC_OFF      = 4'd0,
      SRC_IGNITION = 4'd1,
      SRC_ALWAYS   = 4'd2,
      SRC_LOW_BEAM = 4'd3,
      SRC_HIGH     = 4'd4,
      SRC_ANY_BEAM = 4'd5,
      SRC_ANY_TURN = 4'd6,
      SRC_LEFT     = 4'd7,
      SRC_RIGHT    = 4'd8,
      SRC_HAZARD   = 4'd9,
      SRC_HEATER   = 4'd10,
      SRC_STOP     = 4'd11
   } source_type;

   localparam int OPT_PWM    = 0;
   localparam int OPT_ENGINE = 1;
   localparam int OPT_CUTOFF = 2;
   localparam int OPT_MAX_ON = 3;
   localparam int OPT_DELAY  = 4;

   localparam int SIG_IGN      = 0;
   localparam int SIG_LOW      = 1;
   localparam int SIG_HIGH     = 2;
   localparam int SIG_ANY_BEAM = 3;
   localparam int SIG_ANY_TURN = 4;
   localparam int SIG_LEFT     = 5;
   localparam int SIG_RIGHT    = 6;
   localparam int SIG_HAZARD   = 7;
   localparam int SIG_STOP     = 8;

   typedef struct packed {
      logic [3:0]            source_select;
      logic [4:0]            option_flags;
      logic [7:0]            pwm_percent;
      logic [15:0]           heater_percents;
      logic [15:0]           cutoff_voltage;
      logic [MS_LIMIT_W-1:0] max_on_ms;
      logic [MS_LIMIT_W-1:0] off_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic        ms_tick;
      logic [8:0]  signal_bits;
      logic [1:0]  heater_level;
      logic        engine_running;
      logic [15:0] supply_voltage;
      logic        channel_enable;
   } req_type;

   typedef struct packed {
      logic [CLOCK_W-1:0] ms_clock;
      logic [CLOCK_W-1:0] press_stamp;
      logic [CLOCK_W-1:0] release_stamp;
      logic [1:0]         latched_trigger;
   } state_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              output_on;
   } rsp_type;

   typedef logic [DUTY_W-1:0] duty_table_type [0:PCT_MAX];

   function automatic duty_table_type build_duty_table();
      duty_table_type t;
      for (int i = 0; i <= PCT_MAX; i++) begin
         t[i] = DUTY_W'((i * DUTY_FULL) / PCT_MAX);
      end
      return t;
   endfunction

   localparam duty_table_type DUTY_TABLE = build_duty_table();

   function automatic logic [DUTY_W-1:0] percent_duty(input logic [7:0] pct);
      logic [PCT_W-1:0] idx;
      idx = (pct > 8'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pct[PCT_W-1:0];
      return DUTY_TABLE[idx];
   endfunction

endpackage

`default_nettype wire

// ===== sv/lsc_eval.sv =====
// ----------------------------------------------------------------------------
// Channel evaluation
// Trigger selection, timestamps, gating and duty for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_eval (
   input  lsc_pkg::cfg_type   cfg,
   input  lsc_pkg::req_type   req,
   input  lsc_pkg::state_type state_q,
   output lsc_pkg::state_type state_d,
   output lsc_pkg::rsp_type   rsp
);
   import lsc_pkg::*;

   logic [CLOCK_W-1:0] clock_n;
   logic [1:0]         trig;
   logic               opt_engine;
   logic               opt_delay;
   logic               max_on_expired;
   logic               delay_active;
   logic               can_on;

   always_comb begin
      unique case (cfg.source_select)
         SRC_IGNITION: trig = {1'b0, req.signal_bits[SIG_IGN]};
         SRC_ALWAYS:   trig = 2'd1;
         SRC_LOW_BEAM: trig = {1'b0, req.signal_bits[SIG_LOW]};
         SRC_HIGH:     trig = {1'b0, req.signal_bits[SIG_HIGH]};
         SRC_ANY_BEAM: trig = {1'b0, req.signal_bits[SIG_ANY_BEAM]};
         SRC_ANY_TURN: trig = {1'b0, req.signal_bits[SIG_ANY_TURN]};
         SRC_LEFT:     trig = {1'b0, req.signal_bits[SIG_LEFT]};
         SRC_RIGHT:    trig = {1'b0, req.signal_bits[SIG_RIGHT]};
         SRC_HAZARD:   trig = {1'b0, req.signal_bits[SIG_HAZARD]};
         SRC_HEATER:   trig = (req.heater_level == 2'd3) ? 2'd2 : req.heater_level;
         SRC_STOP:     trig = {1'b0, req.signal_bits[SIG_STOP]};
         default:      trig = 2'd0;
      endcase
   end

   always_comb begin
      clock_n = state_q.ms_clock + CLOCK_W'(req.ms_tick);
      state_d = state_q;
      state_d.ms_clock = clock_n;
      if (trig != state_q.latched_trigger) begin
         if (trig != 2'd0) begin
            state_d.press_stamp = clock_n;
         end else begin
            state_d.release_stamp = clock_n;
         end
         state_d.latched_trigger = trig;
      end
   end

   always_comb begin
      opt_engine = cfg.option_flags[OPT_ENGINE] && (cfg.source_select != SRC_ALWAYS);
      opt_delay  = cfg.option_flags[OPT_DELAY] && (cfg.source_select != SRC_ALWAYS)
                   && (cfg.source_select != SRC_HEATER);
      max_on_expired = cfg.option_flags[OPT_MAX_ON] && (state_d.press_stamp != '0)
                       && ((clock_n - state_d.press_stamp) > CLOCK_W'(cfg.max_on_ms));
      delay_active = opt_delay && (state_d.release_stamp != '0)
                     && ((clock_n - state_d.release_stamp) < CLOCK_W'(cfg.off_delay_ms));

      if (!req.channel_enable) begin
         can_on = 1'b0;
      end else if (opt_engine && !req.engine_running) begin
         can_on = 1'b0;
      end else if (cfg.option_flags[OPT_CUTOFF] && (req.supply_voltage < cfg.cutoff_voltage)) begin
         can_on = 1'b0;
      end else if (max_on_expired) begin
         can_on = 1'b0;
      end else if (state_d.latched_trigger == 2'd0) begin
         can_on = delay_active;
      end else begin
         can_on = 1'b1;
      end

      rsp.output_on = can_on;
      if (!can_on) begin
         rsp.duty = '0;
      end else if (cfg.source_select == SRC_HEATER) begin
         if (state_d.latched_trigger == 2'd1) begin
            rsp.duty = percent_duty(cfg.heater_percents[7:0]);
         end else begin
            rsp.duty = percent_duty(cfg.heater_percents[15:8]);
         end
      end else if (cfg.option_flags[OPT_PWM]) begin
         rsp.duty = percent_duty(cfg.pwm_percent);
      end else begin
         rsp.duty = DUTY_W'(DUTY_FULL);
      end
   end

endmodule

`default_nettype wire

// ===== sv/load_switch_channel_controller_unit.sv =====
// ----------------------------------------------------------------------------
// Load switch channel controller
// One vehicle power output channel with trigger selection and timed gating.
// ----------------------------------------------------------------------------
// The request channel carries one sample of the vehicle signals per request,
// with a flag that advances the internal millisecond clock. Each request
// yields exactly one response on the rsp_ channel: the duty compare value
// and the output state. Both channels use valid and stall.
// A request is registered at acceptance, and its response and the channel state
// are registered from it when the response stage advances; one request is taken
// every cycle while the receiver does not stall.
// While the receiver stalls, the response holds and one more request can be
// taken into the input register; after that the request side stalls too.
// Configuration must be written on the csr_ port only while no request is
// in flight (not enforced); second limits become milliseconds when written.
// Synchronous reset clears the clock, timestamps, trigger, configuration
// and both valid flags; the block takes requests in the cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module load_switch_channel_controller_unit (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire                           req_ms_tick,
   input  wire  [8:0]                    req_signal_bits,
   input  wire  [1:0]                    req_heater_level,
   input  wire                           req_engine_running,
   input  wire  [15:0]                   req_supply_voltage,
   input  wire                           req_channel_enable,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [lsc_pkg::DUTY_W-1:0]    rsp_duty,
   output logic                          rsp_output_on,
   input  wire                           csr_we,
   input  wire  [lsc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire  [lsc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lsc_pkg::*;

   cfg_type   cfg_ff;
   state_type state_ff;
   state_type state_in;
   req_type   req_ff;
   logic      req_valid_ff;
   rsp_type   rsp_in;
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;
   logic      advance;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = req_valid_ff && !advance;

   lsc_eval u_eval (
      .cfg     (cfg_ff),
      .req     (req_ff),
      .state_q (state_ff),
      .state_d (state_in),
      .rsp     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SOURCE_SELECT: cfg_ff.source_select   <= csr_wdata[3:0];
            CSR_OPTION_FLAGS:  cfg_ff.option_flags    <= csr_wdata[4:0];
            CSR_PWM_PERCENT:   cfg_ff.pwm_percent     <= csr_wdata[7:0];
            CSR_HEATER_PCT:    cfg_ff.heater_percents <= csr_wdata;
            CSR_CUTOFF_VOLT:   cfg_ff.cutoff_voltage  <= csr_wdata;
            CSR_MAX_ON_SEC:    cfg_ff.max_on_ms       <= MS_LIMIT_W'(csr_wdata * SEC_TO_MS);
            CSR_OFF_DELAY_SEC: cfg_ff.off_delay_ms    <= MS_LIMIT_W'(csr_wdata * SEC_TO_MS);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
            if (req_valid_ff) begin
               state_ff <= state_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_ff <= '{ms_tick:        req_ms_tick,
                     signal_bits:    req_signal_bits,
                     heater_level:   req_heater_level,
                     engine_running: req_engine_running,
                     supply_voltage: req_supply_voltage,
                     channel_enable: req_channel_enable};
      end
      if (advance && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_duty      = rsp_ff.duty;
   assign rsp_output_on = rsp_ff.output_on;

endmodule

`default_nettype wire

// ===== sv/lsc_checker.sv =====
// ----------------------------------------------------------------------------
// Load switch channel controller checker
// Port-level assertions on the request and response channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lsc_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_valid,
   input wire                            req_stall,
   input wire                            rsp_valid,
   input wire                            rsp_stall,
   input wire [lsc_pkg::DUTY_W-1:0]      rsp_duty,
   input wire                            rsp_output_on
);
   import lsc_pkg::*;

   `LSC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")
   `LSC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_duty) && $stable(rsp_output_on), "stalled response changed")
   `LSC_ASSERT(a_off_zero, clock, reset, rsp_valid && !rsp_output_on |-> rsp_duty == '0, "nonzero duty while off")
   `LSC_ASSERT(a_duty_range, clock, reset, rsp_valid |-> rsp_duty <= DUTY_W'(DUTY_FULL), "duty above full scale")
   `LSC_ASSERT(a_req_moves, clock, reset, !rsp_valid |-> !req_stall, "request stalled with empty response stage")

endmodule

bind load_switch_channel_controller_unit lsc_checker u_lsc_checker (.*);

`default_nettype wire

// ===== tb/load_switch_channel_controller_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load switch channel controller testbench
// Drives vehicle signal samples into the channel controller through the
// request channel, predicts each duty and output state from an internal
// model of the trigger latch, timestamps and gates, and checks every
// response in order. Configuration changes between phases cover all trigger
// sources, the option flags, the register extremes, an expiring zero-second
// on-time limit and an off delay that holds after release.
// ----------------------------------------------------------------------------

module load_switch_channel_controller_unit_test;
   import lsc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   req_type drive_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [DUTY_W-1:0] rsp_duty;
   logic rsp_output_on;
   logic csr_we = 1'b0;
   csr_index_type csr_addr = CSR_SOURCE_SELECT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predicted channel configuration and state.
   logic [3:0]  cfg_source = '0;
   logic [4:0]  cfg_options = '0;
   logic [7:0]  cfg_pwm = '0;
   logic [15:0] cfg_heater = '0;
   logic [15:0] cfg_cutoff = '0;
   logic [15:0] cfg_max_on = '0;
   logic [15:0] cfg_delay = '0;
   logic [31:0] ms_count = '0;
   logic [31:0] press_at = '0;
   logic [31:0] release_at = '0;
   logic [1:0]  trigger_level = '0;

   req_type pending_samples[$];
   rsp_type expected_outputs[$];
   rsp_type want;
   logic idle_on = 1'b1;
   int send_gap = 0;
   int recv_wait = 0;
   int long_hold = 0;
   int responses_taken = 0;
   int error_count = 0;
   int cycle_count = 0;

   load_switch_channel_controller_unit u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_ms_tick(drive_sample.ms_tick),
      .req_signal_bits(drive_sample.signal_bits),
      .req_heater_level(drive_sample.heater_level),
      .req_engine_running(drive_sample.engine_running),
      .req_supply_voltage(drive_sample.supply_voltage),
      .req_channel_enable(drive_sample.channel_enable),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_duty(rsp_duty),
      .rsp_output_on(rsp_output_on),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic rsp_type compute_channel_output(input req_type s);
      logic [1:0]  trig;
      logic        use_engine;
      logic        use_delay;
      logic        drive;
      logic [31:0] max_on_ms;
      logic [31:0] delay_ms;
      logic [31:0] pct;
      logic [31:0] duty;
      rsp_type     r;
      use_engine = cfg_options[OPT_ENGINE] && (cfg_source != SRC_ALWAYS);
      use_delay = cfg_options[OPT_DELAY] && (cfg_source != SRC_ALWAYS) &&
                  (cfg_source != SRC_HEATER);
      max_on_ms = 32'(cfg_max_on) * SEC_TO_MS;
      delay_ms = 32'(cfg_delay) * SEC_TO_MS;
      if (s.ms_tick) begin
         ms_count = ms_count + 32'd1;
      end
      case (cfg_source)
         SRC_IGNITION: trig = {1'b0, s.signal_bits[SIG_IGN]};
         SRC_ALWAYS:   trig = 2'd1;
         SRC_LOW_BEAM: trig = {1'b0, s.signal_bits[SIG_LOW]};
         SRC_HIGH:     trig = {1'b0, s.signal_bits[SIG_HIGH]};
         SRC_ANY_BEAM: trig = {1'b0, s.signal_bits[SIG_ANY_BEAM]};
         SRC_ANY_TURN: trig = {1'b0, s.signal_bits[SIG_ANY_TURN]};
         SRC_LEFT:     trig = {1'b0, s.signal_bits[SIG_LEFT]};
         SRC_RIGHT:    trig = {1'b0, s.signal_bits[SIG_RIGHT]};
         SRC_HAZARD:   trig = {1'b0, s.signal_bits[SIG_HAZARD]};
         SRC_HEATER:   trig = (s.heater_level == 2'd3) ? 2'd2 : s.heater_level;
         SRC_STOP:     trig = {1'b0, s.signal_bits[SIG_STOP]};
         default:      trig = 2'd0;
      endcase
      if (trig != trigger_level) begin
         if (trig != 2'd0) begin
            press_at = ms_count;
         end else begin
            release_at = ms_count;
         end
         trigger_level = trig;
      end
      if (!s.channel_enable) begin
         drive = 1'b0;
      end else if (use_engine && !s.engine_running) begin
         drive = 1'b0;
      end else if (cfg_options[OPT_CUTOFF] && s.supply_voltage < cfg_cutoff) begin
         drive = 1'b0;
      end else if (cfg_options[OPT_MAX_ON] && press_at != 0 &&
                   (ms_count - press_at) > max_on_ms) begin
         drive = 1'b0;
      end else if (trigger_level == 2'd0) begin
         drive = use_delay && release_at != 0 && (ms_count - release_at) < delay_ms;
      end else begin
         drive = 1'b1;
      end
      duty = '0;
      if (drive) begin
         if (cfg_source == SRC_HEATER) begin
            pct = (trigger_level == 2'd1) ? cfg_heater[7:0] : cfg_heater[15:8];
         end else if (cfg_options[OPT_PWM]) begin
            pct = cfg_pwm;
         end else begin
            pct = PCT_MAX;
         end
         if (pct > PCT_MAX) begin
            pct = PCT_MAX;
         end
         duty = (pct * DUTY_FULL) / PCT_MAX;
      end
      r.duty = duty[DUTY_W-1:0];
      r.output_on = drive;
      return r;
   endfunction

   function automatic int draw_wait();
      return idle_on ? int'($urandom_range(0, 11)) : 0;
   endfunction

   function automatic req_type random_sample(input logic [8:0] bits, input logic [1:0] heat);
      req_type s;
      s.ms_tick = 1'($urandom_range(0, 1));
      s.signal_bits = bits;
      s.heater_level = heat;
      s.engine_running = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 1) == 1) begin
         s.supply_voltage = cfg_cutoff + 16'($urandom_range(0, 6)) - 16'd3;
      end else begin
         s.supply_voltage = 16'($urandom);
      end
      s.channel_enable = ($urandom_range(0, 7) != 0);
      return s;
   endfunction

   task automatic add_sample(input logic tick, input logic [8:0] bits, input logic [1:0] heat,
                             input logic engine, input logic [15:0] volts, input logic enable);
      pending_samples.push_back(req_type'{tick, bits, heat, engine, volts, enable});
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_SOURCE_SELECT: cfg_source = value[3:0];
         CSR_OPTION_FLAGS:  cfg_options = value[4:0];
         CSR_PWM_PERCENT:   cfg_pwm = value[7:0];
         CSR_HEATER_PCT:    cfg_heater = value;
         CSR_CUTOFF_VOLT:   cfg_cutoff = value;
         CSR_MAX_ON_SEC:    cfg_max_on = value;
         CSR_OFF_DELAY_SEC: cfg_delay = value;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [3:0] src, input logic [4:0] flags,
                             input logic [7:0] pwm, input logic [15:0] heater,
                             input logic [15:0] cutoff, input logic [15:0] max_on,
                             input logic [15:0] delay_sec);
      write_reg(CSR_SOURCE_SELECT, 16'(src));
      write_reg(CSR_OPTION_FLAGS, 16'(flags));
      write_reg(CSR_PWM_PERCENT, 16'(pwm));
      write_reg(CSR_HEATER_PCT, heater);
      write_reg(CSR_CUTOFF_VOLT, cutoff);
      write_reg(CSR_MAX_ON_SEC, max_on);
      write_reg(CSR_OFF_DELAY_SEC, delay_sec);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pending_samples.size() != 0 || req_valid || expected_outputs.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Driver: presents queued requests with random gaps and holds them while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_outputs.push_back(compute_channel_output(drive_sample));
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               drive_sample <= pending_samples.pop_front();
               req_valid <= 1'b1;
               send_gap = draw_wait();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall, with one long hold-off partway through the run.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses_taken++;
            recv_wait = draw_wait();
            if (responses_taken == 150) begin
               long_hold = 64;
            end
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_stall <= 1'b1;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Monitor: compares each accepted response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            $display("%0t: unexpected response: duty %0d output_on %0b",
                     $time, rsp_duty, rsp_output_on);
            error_count++;
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_duty !== want.duty) begin
               $display("%0t: duty mismatch: expected %0d actual %0d",
                        $time, want.duty, rsp_duty);
               error_count++;
            end
            if (rsp_output_on !== want.output_on) begin
               $display("%0t: output_on mismatch: expected %0b actual %0b",
                        $time, want.output_on, rsp_output_on);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("load_switch_channel_controller_unit_test: FAIL");
         $finish;
      end
   end

   initial begin
      int left;
      int run;
      logic [8:0] bits;
      logic [1:0] heat;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset configuration: source off, so nothing drives.
      add_sample(1'b0, 9'h1FF, 2'd3, 1'b1, 16'hFFFF, 1'b1);
      add_sample(1'b0, 9'h000, 2'd0, 1'b0, 16'h0000, 1'b0);
      wait_idle();

      // Ignition with clamped pwm, undervoltage and a zero on-time limit.
      // The first press happens while the clock is still zero.
      set_config(SRC_IGNITION, 5'b01101, 8'd255, 16'hFFFF, 16'h8000, 16'd0, 16'd0);
      add_sample(1'b0, 9'h001, 2'd0, 1'b1, 16'hFFFF, 1'b1);
      add_sample(1'b1, 9'h001, 2'd0, 1'b1, 16'hFFFF, 1'b1);
      add_sample(1'b0, 9'h001, 2'd0, 1'b1, 16'h7FFF, 1'b1);
      add_sample(1'b0, 9'h001, 2'd0, 1'b1, 16'h8000, 1'b1);
      add_sample(1'b0, 9'h001, 2'd0, 1'b1, 16'hFFFF, 1'b0);
      add_sample(1'b1, 9'h000, 2'd0, 1'b1, 16'hFFFF, 1'b1);
      add_sample(1'b1, 9'h001, 2'd0, 1'b1, 16'hFFFF, 1'b1);
      add_sample(1'b1, 9'h001, 2'd0, 1'b1, 16'hFFFF, 1'b1);
      wait_idle();

      // Heater levels, level three, and the off delay forced off.
      set_config(SRC_HEATER, 5'b10011, 8'd0, 16'h3219, 16'd0, 16'd0, 16'hFFFF);
      add_sample(1'b0, 9'h000, 2'd1, 1'b1, 16'h0000, 1'b1);
      add_sample(1'b0, 9'h000, 2'd2, 1'b1, 16'h0000, 1'b1);
      add_sample(1'b0, 9'h000, 2'd3, 1'b1, 16'h0000, 1'b1);
      add_sample(1'b1, 9'h000, 2'd0, 1'b1, 16'h0000, 1'b1);
      add_sample(1'b0, 9'h000, 2'd1, 1'b0, 16'h0000, 1'b1);
      wait_idle();

      // Always-on ignores the engine-only option.
      set_config(SRC_ALWAYS, 5'b10010, 8'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
      add_sample(1'b1, 9'h000, 2'd0, 1'b0, 16'h0000, 1'b1);
      add_sample(1'b0, 9'h1FF, 2'd0, 1'b0, 16'hFFFF, 1'b0);
      wait_idle();

      // Unused source code.
      set_config(4'd15, 5'h1F, 8'd100, 16'd0, 16'd0, 16'd0, 16'hFFFF);
      add_sample(1'b1, 9'h1FF, 2'd3, 1'b1, 16'hFFFF, 1'b1);
      wait_idle();

      // Stop light with the off delay holding after release.
      set_config(SRC_STOP, 5'b10000, 8'd0, 16'd0, 16'd0, 16'd0, 16'd1);
      add_sample(1'b1, 9'h100, 2'd0, 1'b1, 16'h1234, 1'b1);
      add_sample(1'b1, 9'h000, 2'd0, 1'b1, 16'h1234, 1'b1);
      wait_idle();

      // Random phases, one per source code, with bursts of steady signals.
      for (int p = 0; p < 16; p++) begin
         idle_on = (p % 4 != 1);
         if (p == 3) begin
            set_config(4'(p), 5'h1F, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         end else if (p == 6) begin
            set_config(4'(p), 5'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
         end else begin
            set_config(4'(p), 5'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                       ($urandom_range(0, 1) == 1) ? 16'd0 : 16'($urandom),
                       ($urandom_range(0, 1) == 1) ? 16'd0 : 16'($urandom));
         end
         left = 28;
         while (left > 0) begin
            bits = 9'($urandom);
            heat = 2'($urandom_range(0, 3));
            run = $urandom_range(1, 8);
            for (int k = 0; k < run && left > 0; k++) begin
               if ($urandom_range(0, 5) == 0) begin
                  bits[$urandom_range(0, 8)] = ~bits[$urandom_range(0, 8)];
               end
               pending_samples.push_back(random_sample(bits, heat));
               left--;
            end
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("load_switch_channel_controller_unit_test: PASS");
      end else begin
         $display("load_switch_channel_controller_unit_test: FAIL");
      end
      $finish;
   end

endmodule
